// ===== hw/rtl/debounced_key_event_fifo_top_assert.svh =====
// Assertion macros shared by the debounced key event FIFO RTL.
`ifndef DEBOUNCED_KEY_EVENT_FIFO_TOP_ASSERT_SVH
`define DEBOUNCED_KEY_EVENT_FIFO_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define DKEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define DKEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dkef_pkg.sv =====
// Types and constants of the debounced key event FIFO.
package dkef_pkg;

  localparam int NUM_KEYS   = 4;
  localparam int KEY_W      = 2;
  localparam int PINS_W     = 4;
  localparam int TICKS_W    = 8;
  localparam int EVENT_W    = 3;
  localparam int SCAN_W     = 3;

  localparam logic [1:0] CMD_EDGE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd2;

  typedef struct packed {
    logic             edge_we;
    logic             scan_en;
    logic [KEY_W-1:0] key;
  } cd_ctl_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic             level;
  } push_t;

  typedef struct packed {
    logic             nonempty;
    logic [KEY_W-1:0] ev_key;
    logic             ev_level;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/dkef_ram.sv =====
// Generic simple dual-port RAM with registered read.
module dkef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dkef_countdown.sv =====
// Debounce countdown store with per-key scan and write-back.
`include "debounced_key_event_fifo_top_assert.svh"
module dkef_countdown (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dkef_pkg::cd_ctl_t              ctl,
  input  logic [dkef_pkg::TICKS_W-1:0]   ticks,
  input  logic [dkef_pkg::PINS_W-1:0]    pins,
  output dkef_pkg::push_t                push
);
  import dkef_pkg::*;

  logic [NUM_KEYS-1:0] vld_r, vld_nxt;
  logic                proc_v_r;
  logic [KEY_W-1:0]    proc_k_r;
  logic [TICKS_W-1:0]  rdata, cd_cur, cd_dec;
  logic                running;
  logic                we;
  logic [KEY_W-1:0]    waddr;
  logic [TICKS_W-1:0]  wdata;

  assign cd_cur  = vld_r[proc_k_r] ? rdata : '0;
  assign cd_dec  = cd_cur - 1'b1;
  assign running = proc_v_r && (cd_cur != '0);

  assign we    = ctl.edge_we | running;
  assign waddr = ctl.edge_we ? ctl.key : proc_k_r;
  assign wdata = ctl.edge_we ? ticks : cd_dec;

  assign push.vld   = running && (cd_dec == '0);
  assign push.key   = proc_k_r;
  assign push.level = pins[proc_k_r];

  always_comb begin
    vld_nxt = vld_r;
    if (we) begin
      vld_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      proc_v_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      proc_v_r <= ctl.scan_en;
    end
    proc_k_r <= ctl.key;
  end

  dkef_ram #(.WIDTH(TICKS_W), .DEPTH(NUM_KEYS)) u_cd_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ctl.key),
    .rdata (rdata)
  );

  `DKEF_ASSERT_NOW(a_edge_no_wb, ctl.edge_we, !proc_v_r, "edge write during scan write-back")

endmodule

// ===== hw/rtl/dkef_event_fifo.sv =====
// Ring FIFO of key events held in a RAM, one slot kept free.
`include "debounced_key_event_fifo_top_assert.svh"
module dkef_event_fifo #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dkef_pkg::push_t      push,
  input  logic                 pop,
  output dkef_pkg::fifo_stat_t stat
);
  import dkef_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      wr_next, rd_next;
  logic               full, we;
  logic [EVENT_W-1:0] rdata;

  assign wr_next = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_next = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign full    = (wr_next == rd_ptr_r);
  assign we      = push.vld && !full;

  assign wr_ptr_nxt = we ? wr_next : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_next : rd_ptr_r;

  assign stat.nonempty = (rd_ptr_r != wr_ptr_r);
  assign stat.ev_key   = rdata[EVENT_W-1:1];
  assign stat.ev_level = rdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  dkef_ram #(.WIDTH(EVENT_W), .DEPTH(FIFO_DEPTH)) u_ev_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_ptr_r),
    .wdata ({push.key, push.level}),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  `DKEF_ASSERT_NOW(a_pop_nonempty, pop, stat.nonempty, "pop from empty event FIFO")
  `DKEF_ASSERT_NEXT(a_full_drop, push.vld && full, $stable(wr_ptr_r), "push into full FIFO moved pointer")

endmodule

// ===== hw/rtl/debounced_key_event_fifo_top.sv =====
// Debounced key event FIFO: command sequencer, result register and configuration.
// One beat in gives one beat out. A tick beat walks the countdown memory one key per cycle
// through its single read port, writes each nonzero count back decremented and pushes
// keys that reach zero into the event memory in index order, dropping them when it is full.
// A new beat is taken as soon as the sequencer is idle, while the previous result may
// still wait in the output register.
`include "debounced_key_event_fifo_top_assert.svh"
module debounced_key_event_fifo_top #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [1:0] key_index, [5:2] pin_levels, [7:6] zero
  input  logic [1:0] in_tuser,   // [1:0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [1:0] event_key, [2] event_level, [3] fifo_nonempty
  output logic       out_tuser,  // [0] read_valid
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import dkef_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RDWAIT = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [SCAN_W-1:0]  scan_k_r, scan_k_nxt;
  logic [TICKS_W-1:0] ticks_r;
  logic [PINS_W-1:0]  pins_r;
  logic               res_vld_r, res_vld_nxt;
  logic [KEY_W-1:0]   res_key_r, res_key_nxt;
  logic               res_lvl_r, res_lvl_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [7:0]         out_tdata_r, out_tdata_nxt;
  logic               out_tuser_r, out_tuser_nxt;
  logic               accept, pop;
  cd_ctl_t            cd_ctl;
  push_t              push;
  fifo_stat_t         stat;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign cd_ctl.edge_we = accept && (in_tuser == CMD_EDGE);
  assign cd_ctl.scan_en = (state_r == ST_SCAN) && (scan_k_r < SCAN_W'(NUM_KEYS));
  assign cd_ctl.key     = (state_r == ST_IDLE) ? in_tdata[KEY_W-1:0] : scan_k_r[KEY_W-1:0];
  assign pop            = (state_r == ST_RDWAIT);

  always_comb begin
    state_nxt      = state_r;
    scan_k_nxt     = scan_k_r;
    res_vld_nxt    = res_vld_r;
    res_key_nxt    = res_key_r;
    res_lvl_nxt    = res_lvl_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_vld_nxt = 1'b0;
          res_key_nxt = '0;
          res_lvl_nxt = 1'b0;
          scan_k_nxt  = '0;
          case (in_tuser)
            CMD_TICK: state_nxt = ST_SCAN;
            CMD_READ: state_nxt = stat.nonempty ? ST_RDWAIT : ST_DONE;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_k_r == SCAN_W'(NUM_KEYS)) begin
          state_nxt = ST_DONE;
        end else begin
          scan_k_nxt = scan_k_r + 1'b1;
        end
      end
      ST_RDWAIT: begin
        res_vld_nxt = 1'b1;
        res_key_nxt = stat.ev_key;
        res_lvl_nxt = stat.ev_level;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_vld_r;
          out_tdata_nxt  = {4'b0000, stat.nonempty, res_lvl_r, res_key_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      ticks_r      <= TICKS_RESET;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
    end
    scan_k_r    <= scan_k_nxt;
    res_vld_r   <= res_vld_nxt;
    res_key_r   <= res_key_nxt;
    res_lvl_r   <= res_lvl_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    if (accept) begin
      pins_r <= in_tdata[KEY_W +: PINS_W];
    end
  end

  dkef_countdown u_countdown (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cd_ctl),
    .ticks (ticks_r),
    .pins  (pins_r),
    .push  (push)
  );

  dkef_event_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_event_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (stat)
  );

  `DKEF_ASSERT_NOW(a_rdwait_nonempty, state_r == ST_RDWAIT, stat.nonempty, "read wait with empty FIFO")
  `DKEF_ASSERT_NEXT(a_one_at_a_time, accept, !in_tready, "beat accepted while busy")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the debounced key event FIFO.
module tb_top;
  import dkef_pkg::*;

  localparam int          RING_DEPTH = 128;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic             read_valid;
    logic [KEY_W-1:0] event_key;
    logic             event_level;
    logic             fifo_nonempty;
  } key_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic [1:0] in_tuser = 2'd0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  logic [TICKS_W-1:0] debounce_setting;
  logic [TICKS_W-1:0] key_countdown [NUM_KEYS];
  logic [EVENT_W-1:0] event_ring [RING_DEPTH];
  logic [6:0]         ring_rd;
  logic [6:0]         ring_wr;

  key_result_t results_due[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  debounced_key_event_fifo_top #(.FIFO_DEPTH(RING_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic void ring_push(logic [EVENT_W-1:0] ev);
    if (7'(ring_wr + 7'd1) != ring_rd) begin
      event_ring[ring_wr] = ev;
      ring_wr = ring_wr + 7'd1;
    end
  endfunction

  function automatic key_result_t key_fifo_predict(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                                   logic [PINS_W-1:0] pins);
    key_result_t r;
    logic [EVENT_W-1:0] ev;
    r = '0;
    case (cmd)
      CMD_EDGE: key_countdown[key] = debounce_setting;
      CMD_TICK: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (key_countdown[k] != 0) begin
            key_countdown[k] = key_countdown[k] - 1'b1;
            if (key_countdown[k] == 0) ring_push({KEY_W'(k), pins[k]});
          end
        end
      end
      CMD_READ: begin
        if (ring_rd != ring_wr) begin
          ev = event_ring[ring_rd];
          ring_rd = ring_rd + 7'd1;
          r.read_valid = 1'b1;
          r.event_key = ev[2:1];
          r.event_level = ev[0];
        end
      end
      default: ;
    endcase
    r.fifo_nonempty = (ring_rd != ring_wr);
    return r;
  endfunction

  // take results; stall at random, or hold off for a stretch when asked
  always @(posedge clk) begin
    key_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat tdata=%h tuser=%b", $realtime, out_tdata,
                 out_tuser);
        mismatches++;
      end else begin
        exp_r = results_due.pop_front();
        if (out_tuser !== exp_r.read_valid) begin
          $display("%0t: read_valid expected %b actual %b", $realtime, exp_r.read_valid,
                   out_tuser);
          mismatches++;
        end
        if (out_tdata[1:0] !== exp_r.event_key) begin
          $display("%0t: event_key expected %0d actual %0d", $realtime, exp_r.event_key,
                   out_tdata[1:0]);
          mismatches++;
        end
        if (out_tdata[2] !== exp_r.event_level) begin
          $display("%0t: event_level expected %b actual %b", $realtime, exp_r.event_level,
                   out_tdata[2]);
          mismatches++;
        end
        if (out_tdata[3] !== exp_r.fifo_nonempty) begin
          $display("%0t: fifo_nonempty expected %b actual %b", $realtime,
                   exp_r.fifo_nonempty, out_tdata[3]);
          mismatches++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= 300;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic [KEY_W-1:0] key, logic [PINS_W-1:0] pins);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, pins, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    results_due.push_back(key_fifo_predict(cmd, key, pins));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_debounce(logic [TICKS_W-1:0] ticks);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_setting = ticks;
  endtask

  task automatic test_basic_events();
    send_beat(CMD_READ, 2'd0, 4'h0);
    send_beat(CMD_UNUSED, 2'd3, 4'hF);
    send_beat(CMD_EDGE, 2'd0, 4'h0);
    send_beat(CMD_EDGE, 2'd3, 4'hF);
    send_beat(CMD_TICK, 2'd0, 4'h0);
    send_beat(CMD_EDGE, 2'd0, 4'h5);
    send_beat(CMD_TICK, 2'd1, 4'hF);
    send_beat(CMD_TICK, 2'd2, 4'h0);
    send_beat(CMD_READ, 2'd3, 4'hA);
    send_beat(CMD_READ, 2'd0, 4'h0);
    send_beat(CMD_READ, 2'd1, 4'hF);
    send_beat(CMD_EDGE, 2'd1, 4'h0);
    send_beat(CMD_EDGE, 2'd2, 4'h0);
    send_beat(CMD_TICK, 2'd0, 4'h9);
    send_beat(CMD_TICK, 2'd0, 4'h6);
    send_beat(CMD_READ, 2'd0, 4'h0);
    send_beat(CMD_READ, 2'd0, 4'h0);
    send_beat(CMD_READ, 2'd0, 4'h0);
    send_beat(CMD_TICK, 2'd3, 4'hF);
  endtask

  task automatic test_zero_debounce();
    set_debounce(8'd0);
    send_beat(CMD_EDGE, 2'd1, 4'hF);
    send_beat(CMD_TICK, 2'd0, 4'hF);
    send_beat(CMD_TICK, 2'd0, 4'hF);
    send_beat(CMD_READ, 2'd0, 4'h0);
  endtask

  task automatic test_long_debounce();
    set_debounce(8'd255);
    for (int k = 0; k < NUM_KEYS; k++) send_beat(CMD_EDGE, KEY_W'(k), 4'($urandom_range(15)));
    for (int t = 0; t < 255; t++) send_beat(CMD_TICK, 2'($urandom_range(3)),
                                            4'($urandom_range(15)));
    for (int r = 0; r < NUM_KEYS + 1; r++) send_beat(CMD_READ, 2'd0, 4'h0);
  endtask

  task automatic test_ring_overflow();
    set_debounce(8'd1);
    for (int n = 0; n < 34; n++) begin
      for (int k = 0; k < NUM_KEYS; k++) send_beat(CMD_EDGE, KEY_W'(k), 4'h0);
      send_beat(CMD_TICK, 2'd0, 4'($urandom_range(15)));
    end
    for (int r = 0; r < RING_DEPTH + 2; r++) send_beat(CMD_READ, 2'($urandom_range(3)), 4'h0);
  endtask

  task automatic test_output_backpressure();
    set_debounce(8'd1);
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < 40; n++) begin
      send_beat(2'(n % 3), 2'($urandom_range(3)), 4'($urandom_range(15)));
    end
  endtask

  task automatic test_random_traffic(logic [TICKS_W-1:0] ticks, int idle_pct, int stall_pct,
                                     int count);
    int pick;
    set_debounce(ticks);
    send_idle = idle_pct;
    recv_stall = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) send_beat(CMD_EDGE, 2'($urandom_range(3)), 4'($urandom_range(15)));
      else if (pick < 75) send_beat(CMD_TICK, 2'($urandom_range(3)), 4'($urandom_range(15)));
      else if (pick < 95) send_beat(CMD_READ, 2'($urandom_range(3)), 4'($urandom_range(15)));
      else send_beat(CMD_UNUSED, 2'($urandom_range(3)), 4'($urandom_range(15)));
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  initial begin
    debounce_setting = TICKS_RESET;
    ring_rd = '0;
    ring_wr = '0;
    for (int k = 0; k < NUM_KEYS; k++) key_countdown[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_events();
    test_zero_debounce();
    test_long_debounce();
    test_ring_overflow();
    test_output_backpressure();
    test_random_traffic(8'd1, 0, 0, 280);
    test_random_traffic(8'd2, 70, 0, 280);
    test_random_traffic(8'd4, 0, 70, 280);
    test_random_traffic(8'd7, 32, 32, 280);
    drain_results();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dkef_pkg.sv
hw/rtl/dkef_ram.sv
hw/rtl/dkef_countdown.sv
hw/rtl/dkef_event_fifo.sv
hw/rtl/debounced_key_event_fifo_top.sv
test/tb_top.sv
